>>> sv/assert_macros.svh
// Assertion macros for the top-level RTL file of the pixel converter.
// No dependencies; include by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked at every rising clock edge outside reset.
`define ASSERT_CLK(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) else $error(msg);

// Condition that must never be true outside reset.
`define ASSERT_NEVER(lbl, clk, rst_n, expr, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) !(expr)) else $error(msg);

`endif

>>> sv/byc_pkg.sv
// Shared types, widths and coefficients of the BGR to YCbCr 4:2:0 converter.
// No dependencies.
package byc_pkg;

    localparam int MAX_WIDTH_DEF = 4096;
    localparam int MAX_HEIGHT    = 16384;

    localparam int CH_W         = 8;
    localparam int PIX_W        = 3 * CH_W;
    localparam int ROW_W        = 14;
    localparam int COL_OUT_W    = 12;
    localparam int SRC_WIDTH_W  = 13;
    localparam int SRC_HEIGHT_W = 15;
    localparam int CFG_W        = 15;
    localparam int CFG_IDX_W    = 2;

    localparam logic [SRC_WIDTH_W-1:0]  RST_SRC_WIDTH  = SRC_WIDTH_W'(640);
    localparam logic [SRC_HEIGHT_W-1:0] RST_SRC_HEIGHT = SRC_HEIGHT_W'(480);

    localparam logic [CFG_IDX_W-1:0] CFG_SRC_WIDTH  = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] CFG_SRC_HEIGHT = CFG_IDX_W'(1);

    // 10-bit fixed-point BT.601 full-range coefficients
    localparam int FRAC_BITS  = 10;
    localparam int PROD_W     = 19;
    localparam int COEF_Y_R   = 306;
    localparam int COEF_Y_G   = 601;
    localparam int COEF_Y_B   = 117;
    localparam int COEF_CB_R  = 173;
    localparam int COEF_CB_G  = 339;
    localparam int COEF_CB_B  = 512;
    localparam int COEF_CR_R  = 512;
    localparam int COEF_CR_G  = 429;
    localparam int COEF_CR_B  = 83;
    localparam int CHROMA_OFS = 128;

    typedef struct packed {
        logic [CH_W-1:0] red;
        logic [CH_W-1:0] green;
        logic [CH_W-1:0] blue;
    } t_bgr;

    typedef enum logic [1:0] {
        PLANE_Y  = 2'd0,
        PLANE_CB = 2'd1,
        PLANE_CR = 2'd2
    } t_plane;

endpackage

>>> sv/byc_ram.sv
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
module byc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

>>> sv/byc_csc.sv
// Color space conversion: luma of one pixel, Cb and Cr of a block average.
// Depends on byc_pkg.
module byc_csc (
    input  byc_pkg::t_bgr               i_pix,
    input  byc_pkg::t_bgr               i_avg,
    output logic [byc_pkg::CH_W-1:0]    o_y,
    output logic [byc_pkg::CH_W-1:0]    o_cb,
    output logic [byc_pkg::CH_W-1:0]    o_cr
);
    import byc_pkg::*;

    localparam logic [PROD_W-1:0] OFS = PROD_W'(CHROMA_OFS << FRAC_BITS);

    logic [PROD_W-1:0] y_sum;
    logic [PROD_W-1:0] cb_pos;
    logic [PROD_W-1:0] cb_neg;
    logic [PROD_W-1:0] cb_sum;
    logic [PROD_W-1:0] cr_pos;
    logic [PROD_W-1:0] cr_neg;
    logic [PROD_W-1:0] cr_sum;
    logic [CH_W-1:0]   cb_q;

    always_comb begin
        y_sum = PROD_W'(COEF_Y_R) * PROD_W'(i_pix.red)
              + PROD_W'(COEF_Y_G) * PROD_W'(i_pix.green)
              + PROD_W'(COEF_Y_B) * PROD_W'(i_pix.blue);

        // both sums stay positive and below 2^18 over the whole input range
        cb_pos = PROD_W'(COEF_CB_R) * PROD_W'(i_avg.red)
               + PROD_W'(COEF_CB_G) * PROD_W'(i_avg.green) + OFS;
        cb_neg = PROD_W'(COEF_CB_B) * PROD_W'(i_avg.blue);
        cb_sum = cb_pos - cb_neg;

        cr_pos = PROD_W'(COEF_CR_R) * PROD_W'(i_avg.red) + OFS;
        cr_neg = PROD_W'(COEF_CR_G) * PROD_W'(i_avg.green)
               + PROD_W'(COEF_CR_B) * PROD_W'(i_avg.blue);
        cr_sum = cr_pos - cr_neg;

        cb_q = cb_sum[FRAC_BITS+CH_W-1:FRAC_BITS];
    end

    assign o_y  = y_sum[FRAC_BITS+CH_W-1:FRAC_BITS];
    // 256 - q, with 256 saturating to 255
    assign o_cb = (cb_q == '0) ? '1 : (CH_W'(0) - cb_q);
    assign o_cr = cr_sum[FRAC_BITS+CH_W-1:FRAC_BITS];

endmodule

>>> sv/bgr_to_ycbcr420_converter.sv
// BGR to JPEG BT.601 YCbCr 4:2:0 converter, top level.
// Depends on byc_pkg, byc_ram, byc_csc and assert_macros.svh.
//
// Pixels enter on i_valid/o_stall in raster order, bottom source row first.
// Results leave on o_valid/i_stall: one luma item per pixel inside the
// even-rounded frame, and at the odd column of an odd row a Cb and a Cr item
// follow the luma item. o_last marks the final item of a pixel.
// A pixel's first item passes through the input register and then the result
// group register before it is presented on the output.
// Throughput: one pixel per cycle while the result port is free; the single
// result port sets the limit, so a pixel with three items holds the port until
// all three are taken. Pixels outside the even-rounded frame give no item.
// Configuration writes (i_cfg_we, i_cfg_index, i_cfg_data) set width/height
// and restart the frame; write only while the block is idle.
// Reset: counters to zero, width 640, height 480; the line store is not
// cleared and needs no clearing pass. o_stall is high during reset.
// When the receiver stalls, the output item holds, one more pixel waits in the
// input register, and then o_stall rises.
module bgr_to_ycbcr420_converter #(
    parameter int MAX_WIDTH = byc_pkg::MAX_WIDTH_DEF
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_we,
    input  logic [byc_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [byc_pkg::CFG_W-1:0]        i_cfg_data,
    input  logic                             i_valid,
    output logic                             o_stall,
    input  logic [byc_pkg::CH_W-1:0]         i_blue,
    input  logic [byc_pkg::CH_W-1:0]         i_green,
    input  logic [byc_pkg::CH_W-1:0]         i_red,
    output logic                             o_valid,
    input  logic                             i_stall,
    output byc_pkg::t_plane                  o_plane,
    output logic [byc_pkg::COL_OUT_W-1:0]    o_out_column,
    output logic [byc_pkg::ROW_W-1:0]        o_out_row,
    output logic [byc_pkg::CH_W-1:0]         o_sample,
    output logic                             o_last
);
    import byc_pkg::*;

`include "assert_macros.svh"

    localparam int CW = (MAX_WIDTH > 2) ? $clog2(MAX_WIDTH) : 1;

    // configuration and position counters
    logic [SRC_WIDTH_W-1:0]  r_src_width;
    logic [SRC_HEIGHT_W-1:0] r_src_height;
    logic [CW-1:0]           r_col, n_col;
    logic [ROW_W-1:0]        r_row, n_row;
    logic [CW-1:0]           w_lc;
    logic [ROW_W-1:0]        h_lr;

    // input stage
    logic        in_acc;
    logic        emit_in;
    t_bgr        in_pix;
    logic        r_s1_valid, n_s1_valid;
    t_bgr        r_s1_pix;
    logic [CW-1:0]    r_s1_col;
    logic [ROW_W-1:0] r_s1_row;
    logic        r_s1_emit;
    logic        r_s1_chroma;
    logic        r_s1_pair;
    logic        s1_move;
    t_bgr        top_pix;

    // partial 2x2 sums from the even column of an odd row
    logic [CH_W:0] r_pair_r, r_pair_g, r_pair_b;
    logic [CH_W+1:0] sum_r, sum_g, sum_b;
    t_bgr        avg_pix;
    logic [CH_W-1:0] csc_y, csc_cb, csc_cr;

    // result group register
    logic        r_g_valid, n_g_valid;
    logic        r_g_chroma;
    t_plane      r_g_plane, n_g_plane;
    logic [CW-1:0]    r_g_col;
    logic [ROW_W-1:0] r_g_row;
    logic [CH_W-1:0]  r_g_y, r_g_cb, r_g_cr;
    logic        out_acc;
    logic        g_last;
    logic        g_free;
    logic [CW-1:0]    col_sel;
    logic [31:0]      col_ext;

    // effective last column and last row of the frame
    always_comb begin
        if (r_src_width == '0) begin
            w_lc = '0;
        end else if (32'(r_src_width) > MAX_WIDTH) begin
            w_lc = CW'(MAX_WIDTH - 1);
        end else begin
            w_lc = CW'(r_src_width - SRC_WIDTH_W'(1));
        end
        if (r_src_height == '0) begin
            h_lr = '0;
        end else if (32'(r_src_height) > MAX_HEIGHT) begin
            h_lr = ROW_W'(MAX_HEIGHT - 1);
        end else begin
            h_lr = ROW_W'(r_src_height - SRC_HEIGHT_W'(1));
        end
    end

    assign in_pix  = '{red: i_red, green: i_green, blue: i_blue};
    // odd last column / odd last row fall outside the frame
    assign emit_in = ((r_col != w_lc) || w_lc[0]) && ((r_row != h_lr) || h_lr[0]);

    assign g_last  = r_g_chroma ? (r_g_plane == PLANE_CR) : 1'b1;
    assign out_acc = r_g_valid && !i_stall;
    assign g_free  = !r_g_valid || (out_acc && g_last);
    assign s1_move = r_s1_valid && (!r_s1_emit || g_free);
    assign o_stall = !i_rst_n || (r_s1_valid && !s1_move);
    assign in_acc  = i_valid && !o_stall;

    always_comb begin
        n_col = r_col;
        n_row = r_row;
        if (i_cfg_we) begin
            n_col = '0;
            n_row = '0;
        end else if (in_acc) begin
            if (r_col == w_lc) begin
                n_col = '0;
                n_row = (r_row == h_lr) ? '0 : r_row + ROW_W'(1);
            end else begin
                n_col = r_col + CW'(1);
            end
        end
    end

    always_comb begin
        n_s1_valid = r_s1_valid;
        if (in_acc) begin
            n_s1_valid = 1'b1;
        end else if (s1_move) begin
            n_s1_valid = 1'b0;
        end
    end

    always_comb begin
        n_g_valid = r_g_valid;
        n_g_plane = r_g_plane;
        if (s1_move && r_s1_emit) begin
            n_g_valid = 1'b1;
            n_g_plane = PLANE_Y;
        end else if (out_acc) begin
            if (g_last) begin
                n_g_valid = 1'b0;
            end else begin
                case (r_g_plane)
                    PLANE_Y:  n_g_plane = PLANE_CB;
                    PLANE_CB: n_g_plane = PLANE_CR;
                    default:  n_g_plane = PLANE_Y;
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_src_width  <= RST_SRC_WIDTH;
            r_src_height <= RST_SRC_HEIGHT;
            r_col        <= '0;
            r_row        <= '0;
            r_s1_valid   <= 1'b0;
            r_g_valid    <= 1'b0;
            r_g_plane    <= PLANE_Y;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    CFG_SRC_WIDTH:  r_src_width  <= i_cfg_data[SRC_WIDTH_W-1:0];
                    CFG_SRC_HEIGHT: r_src_height <= i_cfg_data[SRC_HEIGHT_W-1:0];
                    default:        ;
                endcase
            end
            r_col      <= n_col;
            r_row      <= n_row;
            r_s1_valid <= n_s1_valid;
            r_g_valid  <= n_g_valid;
            r_g_plane  <= n_g_plane;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_s1_pix    <= in_pix;
            r_s1_col    <= r_col;
            r_s1_row    <= r_row;
            r_s1_emit   <= emit_in;
            r_s1_chroma <= emit_in && r_row[0] && r_col[0];
            r_s1_pair   <= emit_in && r_row[0] && !r_col[0];
        end
        if (s1_move && r_s1_pair) begin
            r_pair_r <= (CH_W+1)'(r_s1_pix.red)   + (CH_W+1)'(top_pix.red);
            r_pair_g <= (CH_W+1)'(r_s1_pix.green) + (CH_W+1)'(top_pix.green);
            r_pair_b <= (CH_W+1)'(r_s1_pix.blue)  + (CH_W+1)'(top_pix.blue);
        end
        if (s1_move && r_s1_emit) begin
            r_g_chroma <= r_s1_chroma;
            r_g_col    <= r_s1_col;
            r_g_row    <= r_s1_row;
            r_g_y      <= csc_y;
            r_g_cb     <= csc_cb;
            r_g_cr     <= csc_cr;
        end
    end

    // even rows fill the line store, odd rows read the pixel above
    byc_ram #(
        .WIDTH (PIX_W),
        .DEPTH (MAX_WIDTH)
    ) u_line_store (
        .i_clk   (i_clk),
        .i_we    (in_acc && emit_in && !r_row[0]),
        .i_waddr (r_col),
        .i_wdata (in_pix),
        .i_re    (in_acc && emit_in && r_row[0]),
        .i_raddr (r_col),
        .o_rdata (top_pix)
    );

    always_comb begin
        sum_r = (CH_W+2)'(r_pair_r) + (CH_W+2)'(r_s1_pix.red)   + (CH_W+2)'(top_pix.red);
        sum_g = (CH_W+2)'(r_pair_g) + (CH_W+2)'(r_s1_pix.green) + (CH_W+2)'(top_pix.green);
        sum_b = (CH_W+2)'(r_pair_b) + (CH_W+2)'(r_s1_pix.blue)  + (CH_W+2)'(top_pix.blue);
        avg_pix = '{red:   sum_r[CH_W+1:2],
                    green: sum_g[CH_W+1:2],
                    blue:  sum_b[CH_W+1:2]};
    end

    byc_csc u_csc (
        .i_pix (r_s1_pix),
        .i_avg (avg_pix),
        .o_y   (csc_y),
        .o_cb  (csc_cb),
        .o_cr  (csc_cr)
    );

    // chroma planes are half size in both directions
    assign col_sel = (r_g_plane == PLANE_Y) ? r_g_col : (r_g_col >> 1);
    assign col_ext = 32'(col_sel);

    always_comb begin
        case (r_g_plane)
            PLANE_Y:  o_sample = r_g_y;
            PLANE_CB: o_sample = r_g_cb;
            PLANE_CR: o_sample = r_g_cr;
            default:  o_sample = r_g_y;
        endcase
    end

    assign o_valid      = r_g_valid;
    assign o_plane      = r_g_plane;
    assign o_out_column = col_ext[COL_OUT_W-1:0];
    assign o_out_row    = (r_g_plane == PLANE_Y) ? r_g_row : (r_g_row >> 1);
    assign o_last       = g_last;

    `ASSERT_CLK(a_col_bound, i_clk, i_rst_n, r_col <= w_lc, "column count past row end")
    `ASSERT_CLK(a_row_bound, i_clk, i_rst_n, r_row <= h_lr, "row count past frame end")
    `ASSERT_CLK(a_luma_only, i_clk, i_rst_n, (r_g_valid && !r_g_chroma) |-> (r_g_plane == PLANE_Y), "chroma item on a luma-only pixel")
    `ASSERT_CLK(a_chroma_pos, i_clk, i_rst_n, (r_s1_valid && r_s1_chroma) |-> (r_s1_emit && r_s1_col[0] && r_s1_row[0]), "chroma flagged off the odd-odd position")
    `ASSERT_NEVER(a_stall_cause, i_clk, i_rst_n, r_s1_valid && !s1_move && !r_g_valid, "input stalled with a free result register")

endmodule

>>> verif/tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for bgr_to_ycbcr420_converter: random pixels with random
// input gaps and output stalls, checked against a 4:2:0 luma/chroma predictor.
// Depends on byc_pkg and the converter RTL.

module tb;

    import byc_pkg::*;

    typedef struct packed {
        t_plane                 plane;
        logic [COL_OUT_W-1:0]   col;
        logic [ROW_W-1:0]       row;
        logic [CH_W-1:0]        sample_val;
        logic                   last;
    } t_ycc_result;

    class t_ycc_scoreboard;
        t_bgr                   line_buf [MAX_WIDTH_DEF];
        t_bgr                   held;
        int unsigned            col_cnt;
        int unsigned            row_cnt;
        logic [SRC_WIDTH_W-1:0] width_reg;
        logic [SRC_HEIGHT_W-1:0] height_reg;
        t_ycc_result            pending_samples [$];
        int unsigned            mismatches;
        int unsigned            checked;

        function new();
            width_reg  = RST_SRC_WIDTH;
            height_reg = RST_SRC_HEIGHT;
            col_cnt    = 0;
            row_cnt    = 0;
            mismatches = 0;
            checked    = 0;
        endfunction

        // any write, even to a spare index, restarts the frame
        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] data);
            case (idx)
                CFG_SRC_WIDTH:  width_reg = data[SRC_WIDTH_W-1:0];
                CFG_SRC_HEIGHT: height_reg = data[SRC_HEIGHT_W-1:0];
                default: ;
            endcase
            col_cnt = 0;
            row_cnt = 0;
        endfunction

        function void note_pixel(t_bgr px);
            int unsigned w, h, c, r;
            int          ab, ag, ar, cb, cr;
            t_bgr        left, right;
            t_ycc_result res;
            logic        chroma;
            w = width_reg;
            h = height_reg;
            if (w > MAX_WIDTH_DEF) w = MAX_WIDTH_DEF;
            if (w < 1) w = 1;
            if (h > MAX_HEIGHT) h = MAX_HEIGHT;
            if (h < 1) h = 1;
            if (col_cnt >= w) col_cnt = 0;
            if (row_cnt >= h) row_cnt = 0;
            c = col_cnt;
            r = row_cnt;
            if (c < (w & ~32'd1) && r < (h & ~32'd1)) begin
                chroma = r[0] & c[0];
                res.plane = PLANE_Y;
                res.col = COL_OUT_W'(c);
                res.row = ROW_W'(r);
                res.sample_val = CH_W'((COEF_Y_R * int'(px.red) + COEF_Y_G * int'(px.green)
                                       + COEF_Y_B * int'(px.blue)) >>> FRAC_BITS);
                res.last = !chroma;
                pending_samples.push_back(res);
                if (!r[0]) begin
                    line_buf[c] = px;
                end else if (!c[0]) begin
                    held = px;
                end else begin
                    // 2x2 average: two stored pixels of the even row, held pixel, this one
                    left  = line_buf[c-1];
                    right = line_buf[c];
                    ab = (int'(left.blue) + int'(right.blue) + int'(held.blue)
                          + int'(px.blue)) >> 2;
                    ag = (int'(left.green) + int'(right.green) + int'(held.green)
                          + int'(px.green)) >> 2;
                    ar = (int'(left.red) + int'(right.red) + int'(held.red)
                          + int'(px.red)) >> 2;
                    cb = 2 * CHROMA_OFS - ((COEF_CB_R * ar + COEF_CB_G * ag - COEF_CB_B * ab
                                            + (CHROMA_OFS << FRAC_BITS)) >>> FRAC_BITS);
                    if (cb > 255) cb = 255;
                    cr = (COEF_CR_R * ar - COEF_CR_G * ag - COEF_CR_B * ab
                          + (CHROMA_OFS << FRAC_BITS)) >>> FRAC_BITS;
                    res.col = COL_OUT_W'(c >> 1);
                    res.row = ROW_W'(r >> 1);
                    res.plane = PLANE_CB;
                    res.sample_val = CH_W'(cb);
                    res.last = 1'b0;
                    pending_samples.push_back(res);
                    res.plane = PLANE_CR;
                    res.sample_val = CH_W'(cr);
                    res.last = 1'b1;
                    pending_samples.push_back(res);
                end
            end
            if (c + 1 >= w) begin
                col_cnt = 0;
                row_cnt = (r + 1 >= h) ? 0 : r + 1;
            end else begin
                col_cnt = c + 1;
            end
        endfunction

        function void flag(string field, int unsigned want, int unsigned got);
            $display("%0t: %s mismatch, expected %0d, got %0d", $time, field, want, got);
            mismatches++;
        endfunction

        function void check_result(t_ycc_result got);
            t_ycc_result want;
            checked++;
            if (pending_samples.size() == 0) begin
                $display("%0t: unexpected item, expected none, got plane %0d col %0d row %0d",
                         $time, got.plane, got.col, got.row);
                $display("%0t: unexpected item value %0d", $time, got.sample_val);
                mismatches++;
                return;
            end
            want = pending_samples.pop_front();
            if (got.plane !== want.plane) flag("plane", want.plane, got.plane);
            if (got.col !== want.col) flag("out_column", want.col, got.col);
            if (got.row !== want.row) flag("out_row", want.row, got.row);
            if (got.sample_val !== want.sample_val) flag("sample", want.sample_val, got.sample_val);
            if (got.last !== want.last) flag("last", want.last, got.last);
        endfunction
    endclass

    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_A = CFG_IDX_W'(2);
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_B = CFG_IDX_W'(3);
    localparam int RANDOM_PIXELS = 240;
    localparam int DRAIN_CYCLES  = 8;
    localparam int CYCLE_LIMIT   = 500000;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0] i_cfg_index = '0;
    logic [CFG_W-1:0]     i_cfg_data = '0;
    logic                 i_valid = 1'b0;
    logic                 o_stall;
    logic [CH_W-1:0]      i_blue = '0;
    logic [CH_W-1:0]      i_green = '0;
    logic [CH_W-1:0]      i_red = '0;
    logic                 o_valid;
    logic                 i_stall = 1'b0;
    t_plane               o_plane;
    logic [COL_OUT_W-1:0] o_out_column;
    logic [ROW_W-1:0]     o_out_row;
    logic [CH_W-1:0]      o_sample;
    logic                 o_last;

    t_ycc_scoreboard sb;
    int unsigned   cycle_cnt = 0;
    int unsigned   pixels_sent = 0;
    int unsigned   phases = 0;
    logic          quiet = 1'b0;

    bgr_to_ycbcr420_converter dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data),
        .i_valid      (i_valid),
        .o_stall      (o_stall),
        .i_blue       (i_blue),
        .i_green      (i_green),
        .i_red        (i_red),
        .o_valid      (o_valid),
        .i_stall      (i_stall),
        .o_plane      (o_plane),
        .o_out_column (o_out_column),
        .o_out_row    (o_out_row),
        .o_sample     (o_sample),
        .o_last       (o_last)
    );

    always #5 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
    end

    initial begin
        wait (cycle_cnt >= CYCLE_LIMIT);
        $display("%0t: timed out after %0d cycles", $time, cycle_cnt);
        $display("FAIL");
        $finish;
    end

    function automatic int idle_draw();
        return quiet ? 0 : $urandom_range(0, 11);
    endfunction

    // channel values lean toward the rails
    function automatic logic [CH_W-1:0] rand_level();
        case ($urandom_range(0, 7))
            0: return '0;
            1: return '1;
            default: return CH_W'($urandom);
        endcase
    endfunction

    function automatic t_bgr rand_pixel();
        t_bgr px;
        px.red   = rand_level();
        px.green = rand_level();
        px.blue  = rand_level();
        return px;
    endfunction

    task automatic send_pixel(input t_bgr px);
        int gap;
        gap = idle_draw();
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_red   <= px.red;
        i_green <= px.green;
        i_blue  <= px.blue;
        do @(posedge i_clk); while (o_stall !== 1'b0);
        sb.note_pixel(px);
        pixels_sent++;
    endtask

    task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
        @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        sb.write_reg(idx, data);
    endtask

    task automatic set_size(input int w, input int h);
        if ($urandom_range(0, 1)) begin
            cfg_write(CFG_SRC_WIDTH, CFG_W'(w));
            cfg_write(CFG_SRC_HEIGHT, CFG_W'(h));
        end else begin
            cfg_write(CFG_SRC_HEIGHT, CFG_W'(h));
            cfg_write(CFG_SRC_WIDTH, CFG_W'(w));
        end
    endtask

    // called right after the last accepted pixel; pixels without items may
    // still be in the pipe when the queue empties, hence the extra cycles
    task automatic drain();
        i_valid <= 1'b0;
        while (sb.pending_samples.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        phases++;
    endtask

    task automatic run_phase(input int w, input int h, input int n);
        set_size(w, h);
        repeat (n) send_pixel(rand_pixel());
        drain();
    endtask

    // output side: random stall before each item, then take one item
    initial begin
        t_ycc_result got;
        int          n;
        while (i_rst_n !== 1'b1) @(posedge i_clk);
        forever begin
            n = idle_draw();
            if (n > 0) begin
                i_stall <= 1'b1;
                repeat (n) @(posedge i_clk);
                i_stall <= 1'b0;
            end
            do @(posedge i_clk); while (o_valid !== 1'b1);
            got.plane      = o_plane;
            got.col        = o_out_column;
            got.row        = o_out_row;
            got.sample_val = o_sample;
            got.last       = o_last;
            sb.check_result(got);
        end
    end

    initial begin
        int   w, h, n, rand_count;
        t_bgr px;
        sb = new();
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // reset sizes, first row only
        repeat (10) send_pixel(rand_pixel());
        drain();

        // 4x4 frame: blue block (Cb saturates), white, pure red, black
        set_size(4, 4);
        for (int r = 0; r < 4; r++) begin
            for (int c = 0; c < 4; c++) begin
                case ({r[1], c[1]})
                    2'b00:   px = {8'h00, 8'h00, 8'hFF};
                    2'b01:   px = {8'hFF, 8'hFF, 8'hFF};
                    2'b10:   px = {8'hFF, 8'h00, 8'h00};
                    default: px = {8'h00, 8'h00, 8'h00};
                endcase
                send_pixel(px);
            end
        end
        drain();
        run_phase(3, 3, 9);            // odd last column and odd last row

        // degenerate and clamped sizes
        run_phase(0, 4, 6);
        run_phase(1, 4, 4);
        run_phase(4, 0, 6);
        run_phase(4, 1, 5);
        run_phase(32'h7FFF, 32'h7FFF, 16);
        run_phase(MAX_WIDTH_DEF, MAX_HEIGHT, 8);
        run_phase(2, 2, 12);           // three whole frames

        // spare indexes leave sizes alone but restart the frame
        run_phase(4, 4, 6);
        cfg_write(CFG_SPARE_A, CFG_W'($urandom));
        repeat (16) send_pixel(rand_pixel());
        drain();
        cfg_write(CFG_SPARE_B, CFG_W'($urandom));
        repeat (5) send_pixel(rand_pixel());
        drain();

        rand_count = 0;
        while (rand_count < RANDOM_PIXELS) begin
            quiet = ($urandom_range(0, 3) == 0);
            w = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 40) : $urandom_range(2, 10);
            h = $urandom_range(2, 8);
            n = $urandom_range(0, 1) ? w * h * $urandom_range(1, 2) : $urandom_range(1, w * h);
            if (n > 100) n = 100;
            run_phase(w, h, n);
            rand_count += n;
        end

        if (sb.pending_samples.size() != 0) begin
            $display("%0t: %0d expected items never arrived", $time, sb.pending_samples.size());
            sb.mismatches++;
        end
        $display("Sent %0d pixels over %0d phases; checked %0d items, %0d mismatches.",
                 pixels_sent, phases, sb.checked, sb.mismatches);
        $display("Covered reset sizes, zero/one/clamped/odd sizes, spare registers, random frames.");
        if (sb.mismatches == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule
